// File: design/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants of the set-associative cache model: the
// controller command and status groups, opcodes and register indexes.
// ----------------------------------------------------------------------------
package sac_pkg;

   localparam int STAMP_W   = 32;
   localparam int CSR_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int WCNT_W    = 6;
   localparam int IBE_W     = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_IN_USE = 2'd2;

   localparam logic [CSR_W-1:0] OFFSET_BITS_RST = 4'd5;
   localparam logic [CSR_W-1:0] INDEX_BITS_RST  = 4'd6;
   localparam logic [CSR_W-1:0] WAYS_RST        = 4'd1;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_STORE = 1'b1;

   typedef struct packed {
      logic clear;
      logic capture;
      logic lookup;
      logic compare;
      logic scan;
      logic update;
      logic emit;
   } sac_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic need_scan;
      logic scan_done;
      logic rsp_free;
   } sac_status_type;

endpackage

// File: design/sac_controller.sv
// ----------------------------------------------------------------------------
// sac_controller
// Sequencer of the cache: clearing pass, lookup, LRU scan, tag update and
// result hand-off.
// ----------------------------------------------------------------------------
module sac_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  sac_pkg::sac_status_type status,
   output sac_pkg::sac_cmd_type    cmd
);
   import sac_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_COMPARE, ST_SCAN, ST_UPDATE, ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:   if (status.clear_done) state_in = ST_IDLE;
         ST_IDLE:    if (req_valid) state_in = ST_LOOKUP;
         ST_LOOKUP:  state_in = ST_COMPARE;
         ST_COMPARE: state_in = status.need_scan ? ST_SCAN : ST_UPDATE;
         ST_SCAN:    if (status.scan_done) state_in = ST_UPDATE;
         ST_UPDATE:  state_in = ST_DONE;
         ST_DONE:    if (status.rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign cmd.clear   = (state_ff == ST_CLEAR);
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.lookup  = (state_ff == ST_LOOKUP);
   assign cmd.compare = (state_ff == ST_COMPARE);
   assign cmd.scan    = (state_ff == ST_SCAN);
   assign cmd.update  = (state_ff == ST_UPDATE);
   assign cmd.emit    = (state_ff == ST_DONE) && status.rsp_free;

endmodule

// File: design/sac_datapath.sv
// ----------------------------------------------------------------------------
// sac_datapath
// Tag, valid and stamp arrays, two interleaved 64-bit backing memory banks,
// hit and victim selection, recency counter and the result register.
// ----------------------------------------------------------------------------
module sac_datapath #(
   parameter int ADDR_BITS        = 24,
   parameter int MAX_INDEX_BITS   = 10,
   parameter int MAX_WAYS         = 8,
   parameter int MAX_ACCESS_BYTES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sac_pkg::sac_cmd_type           cmd,
   output sac_pkg::sac_status_type        status,
   input  logic [sac_pkg::CSR_W-1:0]      cfg_offset_bits,
   input  logic [sac_pkg::IBE_W-1:0]      cfg_index_bits,
   input  logic [sac_pkg::WCNT_W-1:0]     cfg_ways,
   input  logic                           req_opcode,
   input  logic [ADDR_BITS-1:0]           req_byte_address,
   input  logic [3:0]                     req_access_bytes,
   input  logic [63:0]                    req_write_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_hit,
   output logic [63:0]                    rsp_read_data
);
   import sac_pkg::*;

   localparam int ROW_W     = ADDR_BITS - 4;
   localparam int MEM_DEPTH = 1 << ROW_W;
   localparam int SET_W     = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
   localparam int SETS      = 1 << SET_W;
   localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CLR_W     = (ROW_W > SET_W) ? ROW_W : SET_W;

   logic [63:0]                      bank0_mem [MEM_DEPTH];
   logic [63:0]                      bank1_mem [MEM_DEPTH];
   logic [MAX_WAYS-1:0]              valid_mem [SETS];
   logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tag_mem [SETS];
   logic [MAX_WAYS-1:0][STAMP_W-1:0]   stamp_mem [SETS];

   logic                   op_ff;
   logic [ADDR_BITS-1:0]   addr_ff;
   logic [3:0]             nb_ff;
   logic [63:0]            wdata_ff;
   logic [SET_W-1:0]       set_ff;
   logic [ADDR_BITS-1:0]   tag_ff;
   logic [CLR_W-1:0]       clr_ff;
   logic [63:0]            rd0_ff, rd1_ff;
   logic [MAX_WAYS-1:0]    vrow_ff;
   logic [MAX_WAYS-1:0][ADDR_BITS-1:0] trow_ff;
   logic [MAX_WAYS-1:0][STAMP_W-1:0]   srow_ff;
   logic                   hit_ff;
   logic [WAY_W-1:0]       way_ff;
   logic [WAY_W-1:0]       scan_ff;
   logic [STAMP_W-1:0]     best_ff;
   logic [STAMP_W-1:0]     ctr_ff;
   logic [63:0]            rdata_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [63:0]            rsp_data_ff;

   logic [3:0]             nb_c;
   logic [SET_W:0]         mask_full;
   logic [SET_W-1:0]       set_c;
   logic [ADDR_BITS-1:0]   tag_c;
   logic [ROW_W-1:0]       row_c, b0row, b1row;
   logic [2:0]             bo;
   logic [7:0]             bmask;
   logic [15:0]            be16;
   logic [127:0]           wd128, win, win_sh;
   logic [7:0]             be0, be1;
   logic [63:0]            wd0, wd1, rdata_c;
   logic                   hit_c, free_c;
   logic [WAY_W-1:0]       hway_c, fway_c;
   logic [STAMP_W-1:0]     age_c;
   logic                   touch;
   logic [MAX_WAYS-1:0][ADDR_BITS-1:0] trow_new;
   logic [MAX_WAYS-1:0][STAMP_W-1:0]   srow_new;

   assign nb_c = (req_access_bytes > 4'(MAX_ACCESS_BYTES)) ? 4'(MAX_ACCESS_BYTES)
                                                           : req_access_bytes;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_opcode;
         addr_ff  <= req_byte_address;
         nb_ff    <= nb_c;
         wdata_ff <= req_write_data;
      end
   end

   assign mask_full = ((SET_W+1)'(1) << cfg_index_bits) - (SET_W+1)'(1);
   assign set_c     = SET_W'(addr_ff >> cfg_offset_bits) & mask_full[SET_W-1:0];
   assign tag_c     = addr_ff >> (6'(cfg_offset_bits) + 6'(cfg_index_bits));

   assign row_c = addr_ff[ADDR_BITS-1:4];
   assign b0row = addr_ff[3] ? row_c + ROW_W'(1) : row_c;
   assign b1row = row_c;
   assign bo    = addr_ff[2:0];

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         bmask[i] = (4'(i) < nb_ff);
      end
   end

   assign be16  = 16'(bmask) << bo;
   assign wd128 = 128'(wdata_ff) << {bo, 3'b000};
   assign be0   = addr_ff[3] ? be16[15:8] : be16[7:0];
   assign be1   = addr_ff[3] ? be16[7:0] : be16[15:8];
   assign wd0   = addr_ff[3] ? wd128[127:64] : wd128[63:0];
   assign wd1   = addr_ff[3] ? wd128[63:0] : wd128[127:64];

   assign win    = addr_ff[3] ? {rd0_ff, rd1_ff} : {rd1_ff, rd0_ff};
   assign win_sh = win >> {bo, 3'b000};

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         rdata_c[8*i +: 8] = bmask[i] ? win_sh[8*i +: 8] : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         bank0_mem[clr_ff[ROW_W-1:0]] <= '0;
      end else if (cmd.compare && op_ff == OP_STORE) begin
         for (int i = 0; i < 8; i++) begin
            if (be0[i]) bank0_mem[b0row][8*i +: 8] <= wd0[8*i +: 8];
         end
      end
      if (cmd.lookup) rd0_ff <= bank0_mem[b0row];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         bank1_mem[clr_ff[ROW_W-1:0]] <= '0;
      end else if (cmd.compare && op_ff == OP_STORE) begin
         for (int i = 0; i < 8; i++) begin
            if (be1[i]) bank1_mem[b1row][8*i +: 8] <= wd1[8*i +: 8];
         end
      end
      if (cmd.lookup) rd1_ff <= bank1_mem[b1row];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         valid_mem[clr_ff[SET_W-1:0]] <= '0;
      end else if (cmd.update && op_ff == OP_LOAD && !hit_ff) begin
         valid_mem[set_ff] <= vrow_ff | (MAX_WAYS'(1) << way_ff);
      end
      if (cmd.lookup) vrow_ff <= valid_mem[set_c];
   end

   always_comb begin
      trow_new         = trow_ff;
      trow_new[way_ff] = tag_ff;
      srow_new         = srow_ff;
      srow_new[way_ff] = ctr_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.update && op_ff == OP_LOAD && !hit_ff) begin
         tag_mem[set_ff] <= trow_new;
      end
      if (cmd.lookup) trow_ff <= tag_mem[set_c];
   end

   always_ff @(posedge clock) begin
      if (cmd.update && touch) begin
         stamp_mem[set_ff] <= srow_new;
      end
      if (cmd.lookup) srow_ff <= stamp_mem[set_c];
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         set_ff <= set_c;
         tag_ff <= tag_c;
      end
   end

   always_comb begin
      hit_c  = 1'b0;
      free_c = 1'b0;
      hway_c = '0;
      fway_c = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (WCNT_W'(w) < cfg_ways) begin
            if (vrow_ff[w] && trow_ff[w] == tag_ff) begin
               hit_c  = 1'b1;
               hway_c = WAY_W'(w);
            end
            if (!vrow_ff[w]) begin
               free_c = 1'b1;
               fway_c = WAY_W'(w);
            end
         end
      end
   end

   assign age_c = ctr_ff - srow_ff[scan_ff];
   assign touch = hit_ff || (op_ff == OP_LOAD);

   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         hit_ff   <= hit_c;
         way_ff   <= hit_c ? hway_c : fway_c;
         scan_ff  <= '0;
         rdata_ff <= (op_ff == OP_STORE) ? 64'h0 : rdata_c;
      end else if (cmd.scan) begin
         if (scan_ff == '0 || age_c > best_ff) begin
            best_ff <= age_c;
            way_ff  <= scan_ff;
         end
         scan_ff <= scan_ff + WAY_W'(1);
      end
      if (cmd.emit) begin
         rsp_hit_ff  <= hit_ff;
         rsp_data_ff <= rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         ctr_ff       <= STAMP_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + CLR_W'(1);
         if (cmd.update && touch) ctr_ff <= ctr_ff + STAMP_W'(1);
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.clear_done = &clr_ff;
   assign status.need_scan  = (op_ff == OP_LOAD) && !hit_c && !free_c;
   assign status.scan_done  = (WCNT_W'(scan_ff) + WCNT_W'(1) == cfg_ways);
   assign status.rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

// File: design/set_assoc_lru_cache_model.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Set-associative LRU cache, write-through and no-write-allocate, in front
// of a byte-addressed backing memory held in two interleaved 64-bit banks.
//
// Requests enter on req_* (valid/stall), one result per request leaves on
// rsp_* (valid/stall). Registers offset_bits, index_bits and ways_in_use
// are written through csr_* with no wait; the user writes them only while
// the block is idle, which the block does not enforce. A request passes
// through the lookup, compare, update and done states before rsp_valid
// rises; a load miss that finds the set full adds a victim search that
// walks the set one way per cycle. At most one request is in flight; the
// next is taken in the cycle after the result enters the output register.
// A stalled receiver holds the next result in the datapath and keeps
// req_stall high until the output register frees. After reset a clearing
// pass zeroes one row of each memory bank and of the valid array per
// cycle, with req_stall high.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model #(
   parameter int ADDR_BITS        = 24,
   parameter int MAX_INDEX_BITS   = 10,
   parameter int MAX_WAYS         = 8,
   parameter int MAX_ACCESS_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_enable,
   input  logic [sac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sac_pkg::CSR_W-1:0]        csr_write_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_opcode,
   input  logic [ADDR_BITS-1:0]             req_byte_address,
   input  logic [3:0]                       req_access_bytes,
   input  logic [63:0]                      req_write_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_hit,
   output logic [63:0]                      rsp_read_data
);
   import sac_pkg::*;

   logic [CSR_W-1:0]  offset_bits_ff, index_bits_ff, ways_ff;
   logic [IBE_W-1:0]  ib_eff;
   logic [WCNT_W-1:0] ways_eff;
   sac_cmd_type       cmd;
   sac_status_type    status;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OFFSET_BITS_RST;
         index_bits_ff  <= INDEX_BITS_RST;
         ways_ff        <= WAYS_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_OFFSET_BITS: offset_bits_ff <= csr_write_data;
            CSR_INDEX_BITS:  index_bits_ff  <= csr_write_data;
            CSR_WAYS_IN_USE: ways_ff        <= csr_write_data;
            default:         ;
         endcase
      end
   end

   assign ib_eff = (IBE_W'(index_bits_ff) > IBE_W'(MAX_INDEX_BITS))
                   ? IBE_W'(MAX_INDEX_BITS) : IBE_W'(index_bits_ff);

   always_comb begin
      if (ways_ff == '0) begin
         ways_eff = WCNT_W'(1);
      end else if (WCNT_W'(ways_ff) > WCNT_W'(MAX_WAYS)) begin
         ways_eff = WCNT_W'(MAX_WAYS);
      end else begin
         ways_eff = WCNT_W'(ways_ff);
      end
   end

   sac_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sac_datapath #(
      .ADDR_BITS        (ADDR_BITS),
      .MAX_INDEX_BITS   (MAX_INDEX_BITS),
      .MAX_WAYS         (MAX_WAYS),
      .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg_offset_bits  (offset_bits_ff),
      .cfg_index_bits   (ib_eff),
      .cfg_ways         (ways_eff),
      .req_opcode       (req_opcode),
      .req_byte_address (req_byte_address),
      .req_access_bytes (req_access_bytes),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_read_data    (rsp_read_data)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result raised one cycle after acceptance");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request port open during clearing pass");
`endif

endmodule

// File: test/set_assoc_lru_cache_model_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_checker
// Watches the register writes and both channels of the cache model. For
// every accepted request it predicts the hit flag and the loaded bytes
// with its own copy of the tags, recency stamps and backing memory, and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [sac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sac_pkg::CSR_W-1:0]     csr_write_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [23:0]                   req_byte_address,
   input  logic [3:0]                    req_access_bytes,
   input  logic [63:0]                   req_write_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_hit,
   input  logic [63:0]                   rsp_read_data,
   output int                            error_count,
   output int                            pending_count
);
   import sac_pkg::*;

   localparam int SETS = 1024;
   localparam int WAYS = 8;

   typedef struct {
      logic        hit;
      logic [63:0] read_data;
   } cache_result_type;

   logic [CSR_W-1:0] offset_bits;
   logic [CSR_W-1:0] index_bits;
   logic [CSR_W-1:0] ways_in_use;
   bit               line_valid [SETS*WAYS];
   bit [23:0]        line_tag   [SETS*WAYS];
   bit [31:0]        line_stamp [SETS*WAYS];
   bit [31:0]        use_count;
   bit [7:0]         memory_bytes [int];
   cache_result_type expected_results [$];

   assign pending_count = expected_results.size();

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch %s got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic cache_result_type predict_access(input logic op,
         input logic [23:0] addr, input logic [3:0] nb_raw, input logic [63:0] wdata);
      cache_result_type r;
      int ib, ways, nb, set_no, base, slot, victim;
      bit [23:0] tag, a;
      bit [31:0] age, best_age;
      bit found, have_free, have_best;
      ib = (index_bits > 10) ? 10 : index_bits;
      ways = (ways_in_use == 0) ? 1 : ((ways_in_use > WAYS) ? WAYS : ways_in_use);
      nb = (nb_raw > 8) ? 8 : nb_raw;
      set_no = (addr >> offset_bits) & ((1 << ib) - 1);
      tag = addr >> (offset_bits + ib);
      base = set_no * WAYS;
      found = 0;
      slot = 0;
      r.read_data = '0;
      for (int w = 0; w < ways; w++) begin
         if (!found && line_valid[base+w] && line_tag[base+w] == tag) begin
            found = 1;
            slot = base + w;
         end
      end
      for (int i = 0; i < nb; i++) begin
         a = addr + i;
         if (op == OP_STORE) begin
            memory_bytes[a] = wdata[8*i +: 8];
         end else if (memory_bytes.exists(a)) begin
            r.read_data[8*i +: 8] = memory_bytes[a];
         end
      end
      if (found) begin
         line_stamp[slot] = use_count;
         use_count++;
      end else if (op == OP_LOAD) begin
         have_free = 0;
         have_best = 0;
         victim = base;
         best_age = 0;
         for (int w = 0; w < ways; w++) begin
            if (!have_free && !line_valid[base+w]) begin
               victim = base + w;
               have_free = 1;
            end
         end
         if (!have_free) begin
            for (int w = 0; w < ways; w++) begin
               age = use_count - line_stamp[base+w];
               if (!have_best || age > best_age) begin
                  best_age = age;
                  victim = base + w;
                  have_best = 1;
               end
            end
         end
         line_valid[victim] = 1;
         line_tag[victim] = tag;
         line_stamp[victim] = use_count;
         use_count++;
      end
      r.hit = found;
      return r;
   endfunction

   always @(posedge clock) begin
      cache_result_type want;
      if (reset) begin
         offset_bits = OFFSET_BITS_RST;
         index_bits = INDEX_BITS_RST;
         ways_in_use = WAYS_RST;
         foreach (line_valid[i]) line_valid[i] = 0;
         use_count = 1;
         memory_bytes.delete();
         expected_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_OFFSET_BITS: offset_bits = csr_write_data;
               CSR_INDEX_BITS:  index_bits = csr_write_data;
               CSR_WAYS_IN_USE: ways_in_use = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", {63'd0, rsp_hit}, 64'd0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch("hit", {63'd0, rsp_hit}, {63'd0, want.hit});
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", rsp_read_data, want.read_data);
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(predict_access(req_opcode, req_byte_address,
                  req_access_bytes, req_write_data));
      end
   end

   initial error_count = 0;
endmodule

// File: test/set_assoc_lru_cache_model_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_tb
// Drives loads and stores into the cache model over a series of cache
// geometries, with random gaps and receiver stalls, and lets the checker
// judge every result.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model_tb;
   import sac_pkg::*;

   localparam int IDLE_LIMIT = 4_000_000;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 csr_write_enable = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_OFFSET_BITS;
   logic [CSR_W-1:0]     csr_write_data = '0;
   logic                 req_valid = 0;
   logic                 req_stall;
   logic                 req_opcode = OP_LOAD;
   logic [23:0]          req_byte_address = '0;
   logic [3:0]           req_access_bytes = '0;
   logic [63:0]          req_write_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 0;
   logic                 rsp_hit;
   logic [63:0]          rsp_read_data;
   int                   error_count;
   int                   pending_count;
   int                   sent_count = 0;
   int                   done_count = 0;
   int                   idle_cycles = 0;
   int                   stall_mode = 0;
   bit                   hold_done = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   set_assoc_lru_cache_model u_dut (.*);

   set_assoc_lru_cache_model_checker u_checker (.*);

   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) done_count++;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("set_assoc_lru_cache_model test failed");
            $finish;
         end
      end
   end

   function automatic int random_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!hold_done && rsp_valid && done_count > 20) begin
            rsp_stall <= 1;
            repeat (400) @(negedge clock);
            hold_done = 1;
         end
         case (stall_mode)
            0: rsp_stall <= 0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: begin
               gap = random_gap();
               if (gap > 0) begin
                  rsp_stall <= 1;
                  repeat (gap) @(negedge clock);
               end
               rsp_stall <= 0;
               repeat (random_gap()) @(negedge clock);
            end
         endcase
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   task automatic send_request(input logic op, input logic [23:0] addr,
                               input logic [3:0] nb, input logic [63:0] wdata,
                               input int gap);
      req_valid <= 1;
      req_opcode <= op;
      req_byte_address <= addr;
      req_access_bytes <= nb;
      req_write_data <= wdata;
      while (req_stall) @(negedge clock);
      @(posedge clock);
      sent_count++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (done_count != sent_count) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   initial begin
      int ob [12];
      int ib [12];
      int wy [12];
      int shift, ibe;
      logic [23:0] addr;
      ob = '{0, 12, 3, 5, 1, 7, 2, 4, 0, 6, 12, 8};
      ib = '{0, 10, 15, 2, 3, 1, 11, 4, 2, 0, 6, 1};
      wy = '{8, 0, 15, 4, 2, 3, 8, 5, 1, 7, 6, 8};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_request(OP_STORE, 24'h000000, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      send_request(OP_LOAD, 24'h000000, 4'd8, 64'd0, 1);
      send_request(OP_LOAD, 24'h000000, 4'd8, 64'd0, 0);
      send_request(OP_STORE, 24'h000004, 4'd15, 64'h0123_4567_89AB_CDEF, 0);
      send_request(OP_STORE, 24'h000010, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      send_request(OP_LOAD, 24'h000000, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 2);
      send_request(OP_STORE, 24'hFFFFFC, 4'd8, 64'hA5A5_5A5A_C3C3_3C3C, 0);
      send_request(OP_LOAD, 24'hFFFFFC, 4'd8, 64'd0, 0);
      send_request(OP_LOAD, 24'hFFFFFF, 4'd1, 64'd0, 0);
      send_request(OP_LOAD, 24'h000800, 4'd4, 64'd0, 0);
      send_request(OP_LOAD, 24'h000000, 4'd4, 64'd0, 0);
      send_request(OP_STORE, 24'h000800, 4'd2, 64'h0000_0000_0000_BEEF, 0);
      send_request(OP_LOAD, 24'h000800, 4'd0, 64'd0, 0);
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         write_reg(CSR_OFFSET_BITS, CSR_W'(ob[ph]));
         write_reg(CSR_INDEX_BITS, CSR_W'(ib[ph]));
         write_reg(CSR_WAYS_IN_USE, CSR_W'(wy[ph]));
         stall_mode = ph % 3;
         ibe = (ib[ph] > 10) ? 10 : ib[ph];
         shift = ob[ph] + ibe;
         for (int n = 0; n < 128; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               addr = 24'($urandom());
            end else begin
               addr = 24'(($urandom_range(0, 10) << shift)
                    | ($urandom_range(0, 2) << ob[ph])
                    | ($urandom() & ((1 << ob[ph]) - 1)));
               if ($urandom_range(0, 19) == 0) addr = addr | 24'hFFFFF0;
            end
            send_request($urandom_range(0, 2) == 0 ? OP_STORE : OP_LOAD, addr,
                         4'($urandom_range(0, 15)), {$urandom(), $urandom()},
                         (ph % 4 == 3) ? 0 : random_gap());
         end
         drain();
      end

      stall_mode = 0;
      drain();
      if (error_count == 0 && pending_count == 0)
         $display("set_assoc_lru_cache_model test passed");
      else
         $display("set_assoc_lru_cache_model test failed");
      $finish;
   end
endmodule

// File: set_assoc_lru_cache_model.f
design/sac_pkg.sv
design/sac_controller.sv
design/sac_datapath.sv
design/set_assoc_lru_cache_model.sv
test/set_assoc_lru_cache_model_checker.sv
test/set_assoc_lru_cache_model_tb.sv
